// ----- hdl/bfsa_pkg.sv -----
// Shared types for the bump-and-free-stack index allocator.
// Holds opcode and status codes and the command record passed front to back.
// No dependencies.
package bfsa_pkg;

	localparam int unsigned IDX_W   = 12;
	localparam int unsigned USED_W  = 13;
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAN = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_OVER = 2'd2
	} stat_t;

	// One decoded request waiting in the command queue.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] index;
	} cmd_t;

	// Handshake between the command queue and the execution side.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

// ----- hdl/bump_and_free_stack_index_allocator.sv -----
// Index allocator: bump counter first, then a LIFO stack of freed indices.
// Throughput: one transaction per cycle unless the output stalls; a stack pop
// holds the back end in BK_POP for the registered read of the stack memory.
// Reset: arst_n clears counters, high-water mark, queue and output valid;
// stack contents are not cleared, only entries below the depth are ever read.
module bump_and_free_stack_index_allocator
	import bfsa_pkg::*;
#(
	parameter int unsigned CAPACITY = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [11:0] freed_index, [15:12] zero
	input  logic [1:0]          s_tuser,  // [1:0] opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	// [11:0] slot_index, [13:12] status, [14] first_use, [27:15] used_count,
	// [31:28] zero
	output logic [M_DATA_W-1:0] m_tdata
);

	// decoded command from the front queue to the execution side
	cmd_req_t req;
	logic     req_ready;

	// Front: take each transaction, decode the opcode, park it in the queue so
	// the input keeps flowing while the back end waits on the output.
	bfsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.req       (req),
		.req_ready (req_ready)
	);

	// Back: advance the bump counter, push or pop the free stack, and hold
	// each result in the output register until the sink takes it.
	bfsa_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (req_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- hdl/bfsa_front.sv -----
// Front side of the allocator: accepts stream requests and decodes them.
// Decoded commands wait in a two-entry queue. Depends on bfsa_pkg.
module bfsa_front
	import bfsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [11:0] freed_index, [15:12] zero
	input  logic [1:0]          s_tuser,  // [1:0] opcode
	output cmd_req_t            req,
	input  logic                req_ready
);

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       decoded;

	always_comb begin
		decoded.op    = op_t'(s_tuser);
		decoded.index = s_tdata[IDX_W-1:0];
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign req.valid = (count_q != 2'd0);
	assign req.cmd   = queue_q[rd_ptr_q];
	assign pop       = req.valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= decoded;
	end

endmodule

// ----- hdl/bfsa_back.sv -----
// Back side of the allocator: bump counter, high-water mark and free stack.
// Executes queued commands and fills the output register. Depends on bfsa_pkg.
module bfsa_back
	import bfsa_pkg::*;
#(
	parameter int unsigned CAPACITY = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_req_t            req,
	output logic                req_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {
		BK_EXEC = 2'b01,
		BK_POP  = 2'b10
	} bk_state_t;

	bk_state_t         state_q, state_d;
	logic [CW-1:0]     bump_q, bump_d;
	logic [CW-1:0]     depth_q, depth_d;
	logic [CW-1:0]     hw_q, hw_d;
	logic [CW-1:0]     depth_m1;
	logic [IDX_W-1:0]  stack_mem [CAPACITY];
	logic [IDX_W-1:0]  rd_data_q;
	logic              wr_en;
	logic              rd_en;
	logic              out_free;
	logic              load_out;
	logic [IDX_W-1:0]  out_slot;
	stat_t             out_stat;
	logic              out_first;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign depth_m1 = depth_q - 1'b1;

	always_comb begin
		state_d   = state_q;
		bump_d    = bump_q;
		depth_d   = depth_q;
		hw_d      = hw_q;
		req_ready = 1'b0;
		load_out  = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		out_slot  = '0;
		out_stat  = STAT_OK;
		out_first = 1'b0;
		unique case (state_q)
			BK_EXEC: begin
				if (req.valid && out_free) begin
					req_ready = 1'b1;
					unique case (req.cmd.op)
						OP_ALLOC: begin
							priority if (bump_q < CAP_C) begin
								load_out = 1'b1;
								out_slot = IDX_W'(bump_q);
								bump_d   = bump_q + 1'b1;
								if (hw_q < bump_d) begin
									hw_d      = bump_d;
									out_first = 1'b1;
								end
							end else if (depth_q != '0) begin
								// result comes out once the stack read returns
								depth_d = depth_m1;
								rd_en   = 1'b1;
								state_d = BK_POP;
							end else begin
								load_out = 1'b1;
								out_stat = STAT_FULL;
							end
						end
						OP_FREE: begin
							load_out = 1'b1;
							if (depth_q < CAP_C) begin
								wr_en   = 1'b1;
								depth_d = depth_q + 1'b1;
							end else begin
								out_stat = STAT_OVER;
							end
						end
						OP_CLEAN: begin
							load_out = 1'b1;
							bump_d   = '0;
							depth_d  = '0;
						end
						OP_QUERY: begin
							load_out = 1'b1;
						end
						default: ;
					endcase
				end
			end
			BK_POP: begin
				if (out_free) begin
					load_out = 1'b1;
					out_slot = rd_data_q;
					state_d  = BK_EXEC;
				end
			end
			default: state_d = BK_EXEC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_EXEC;
			bump_q     <= '0;
			depth_q    <= '0;
			hw_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bump_q  <= bump_d;
			depth_q <= depth_d;
			hw_q    <= hw_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {4'd0, USED_W'(bump_d), out_first, out_stat, out_slot};
		end
	end

	// free stack storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) stack_mem[depth_q[AW-1:0]] <= req.cmd.index;
		if (rd_en) rd_data_q <= stack_mem[depth_m1[AW-1:0]];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
